/* rtl/core/ubh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_pkg
// Shared types and codes of the uniform-bin histogram engine.
// ----------------------------------------------------------------------------
package ubh_pkg;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        [5:0]  bin_index;
    logic signed [39:0] bin_edge;
    logic        [31:0] bin_count;
    logic        [31:0] peak_count;
    logic        [31:0] below_count;
    logic        [31:0] above_count;
    logic               last_bin;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] bin_start;
    logic        [30:0] bin_width;
    logic        [6:0]  bin_total;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_BIN_START = 2'd0,
    REG_BIN_WIDTH = 2'd1,
    REG_BIN_TOTAL = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    CMD_BELOW  = 2'd0,
    CMD_OVER   = 2'd1,
    CMD_DIVIDE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] diff;
  } cmd_t;

  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

/* rtl/core/ubh_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_front
// Accepts requests and classifies them: readout, below, above, or a sample
// offset that needs a bin lookup.
// ----------------------------------------------------------------------------
module ubh_front import ubh_pkg::*; (
  input  wire  in_item_t in_item_i,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  wire  cfg_t     cfg_i,
  input  wire            queue_full_i,
  input  wire            accepting_i,
  output logic           push_o,
  output cmd_t           cmd_o
);

  logic        below;
  logic [31:0] diff;

  assign below = in_item_i.sample < cfg_i.bin_start;
  assign diff  = $unsigned(in_item_i.sample - cfg_i.bin_start);

  assign in_ready_o = !queue_full_i && accepting_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.diff = diff;
    if (in_item_i.operation) begin
      cmd_o.kind = CMD_READ;
    end else if (below) begin
      cmd_o.kind = CMD_BELOW;
    end else if (cfg_i.bin_width == '0) begin
      cmd_o.kind = CMD_OVER;
    end else begin
      cmd_o.kind = CMD_DIVIDE;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ubh_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ubh_queue import ubh_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire  cmd_t cmd_i,
  output logic       full_o,
  input  wire        pop_i,
  output logic       valid_o,
  output cmd_t       cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ubh_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ubh_divider import ubh_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] dividend_i,
  input  wire  [30:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [30:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] shifted;
  logic [31:0] trial;
  logic        fits;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, divisor_i};
  assign fits    = shifted >= {1'b0, divisor_i};

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[30:0] : shifted[30:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule
`default_nettype wire

/* rtl/core/ubh_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ubh_back
// Executes queued requests: bin counter memory read-modify-write, below and
// above counters, peak tracking, readout sweep with clear, result register.
// ----------------------------------------------------------------------------
module ubh_back import ubh_pkg::*; #(
  parameter int unsigned MAX_BINS = 64
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire  cfg_t      cfg_i,
  input  wire             cmd_valid_i,
  input  wire  cmd_t      cmd_i,
  output logic            cmd_pop_o,
  output logic            accepting_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output out_item_t       out_item_o
);

  localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NW = $clog2(MAX_BINS + 1);
  localparam int unsigned EW = (33 + AW > 40) ? 33 + AW : 40;
  localparam logic [AW-1:0] LastIdx = AW'(MAX_BINS - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DIV    = 6'b000100,
    S_ACC    = 6'b001000,
    S_RO_RD  = 6'b010000,
    S_RO_OUT = 6'b100000
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == CntMax) ? c : c + 32'd1;
  endfunction

  state_e         state_q, state_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [EW-1:0]  edge_q, edge_d;
  logic [31:0]    under_q, under_d;
  logic [31:0]    over_q, over_d;
  logic [31:0]    peak_q, peak_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  logic [31:0]    mem [MAX_BINS];
  logic [31:0]    rd_data_q;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [31:0]    wr_data;

  logic           div_start;
  logic           div_done;
  logic [31:0]    quotient;

  logic [NW-1:0]  n_bins;
  logic           in_use;
  logic           last_in_use;
  logic           out_free;
  logic           out_load;
  logic [31:0]    inc;
  logic [AW+5:0]  idx_ext;

  ubh_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.diff),
    .divisor_i  (cfg_i.bin_width),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (cfg_i.bin_total == '0) begin
      n_bins = NW'(1);
    end else if (32'(cfg_i.bin_total) > 32'(MAX_BINS)) begin
      n_bins = NW'(MAX_BINS);
    end else begin
      n_bins = NW'(cfg_i.bin_total);
    end
  end

  assign in_use      = 32'(idx_q) < 32'(n_bins);
  assign last_in_use = (32'(idx_q) + 32'd1) == 32'(n_bins);
  assign out_free    = !out_valid_q || out_ready_i;
  assign inc         = sat_inc(rd_data_q);
  assign idx_ext     = {6'b0, idx_q};
  assign accepting_o = state_q != S_CLEAR;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    edge_d    = edge_q;
    under_d   = under_q;
    over_d    = over_q;
    peak_d    = peak_q;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_data   = '0;
    out_load  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_BELOW:  under_d = sat_inc(under_q);
            CMD_OVER:   over_d  = sat_inc(over_q);
            CMD_DIVIDE: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            CMD_READ: begin
              idx_d   = '0;
              edge_d  = {{(EW-32){cfg_i.bin_start[31]}}, cfg_i.bin_start};
              state_d = S_RO_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (quotient < 32'(n_bins)) begin
            rd_en   = 1'b1;
            rd_addr = quotient[AW-1:0];
            idx_d   = quotient[AW-1:0];
            state_d = S_ACC;
          end else begin
            over_d  = sat_inc(over_q);
            state_d = S_IDLE;
          end
        end
      end
      S_ACC: begin
        wr_en   = 1'b1;
        wr_data = inc;
        if (inc > peak_q) begin
          peak_d = inc;
        end
        state_d = S_IDLE;
      end
      S_RO_RD: begin
        rd_en   = 1'b1;
        state_d = S_RO_OUT;
      end
      S_RO_OUT: begin
        if (!in_use || out_free) begin
          wr_en    = 1'b1;
          out_load = in_use;
          if (idx_q == LastIdx) begin
            under_d = '0;
            over_d  = '0;
            peak_d  = '0;
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            edge_d  = edge_q + EW'(cfg_i.bin_width);
            state_d = S_RO_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d       = 1'b1;
      out_d.bin_index   = idx_ext[5:0];
      out_d.bin_edge    = $signed(edge_q[39:0]);
      out_d.bin_count   = rd_data_q;
      out_d.peak_count  = peak_q;
      out_d.below_count = under_q;
      out_d.above_count = over_q;
      out_d.last_bin    = last_in_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      under_q     <= '0;
      over_q      <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      under_q     <= under_d;
      over_q      <= over_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* rtl/core/uniform_bin_histogram.sv */
// Accumulate: a request is accepted into a two-entry queue. The back end runs a sample
// inside the bins through the divider, a read and a write, one at or above the last
// edge through the divider alone; one below the start, or any when the width is zero,
// is counted on pop. The back end takes a new request only when done with the last.
// Readout: a read and an output step per slot of all MAX_BINS, held while results stall.
// Reset: a clearing pass zeroes the bin memory; no request is taken until it ends.
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_bin_histogram
// Uniform-bin histogram of signed Q16.16 samples with below/above counters,
// running peak and a readout that reports every bin in use and clears every bin slot.
// ----------------------------------------------------------------------------
module uniform_bin_histogram import ubh_pkg::*; #(
  parameter int unsigned MAX_BINS = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire  in_item_t   in_item_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output out_item_t        out_item_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  [1:0]       cfg_index_i,
  input  wire  [31:0]      cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic queue_valid;
  cmd_t queue_cmd;
  logic queue_pop;
  logic accepting;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_BIN_START: cfg_d.bin_start = $signed(cfg_data_i);
        REG_BIN_WIDTH: cfg_d.bin_width = cfg_data_i[30:0];
        REG_BIN_TOTAL: cfg_d.bin_total = cfg_data_i[6:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_start <= 32'sd0;
      cfg_q.bin_width <= 31'd65536;
      cfg_q.bin_total <= 7'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ubh_front u_front (
    .in_item_i    (in_item_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cfg_i        (cfg_q),
    .queue_full_i (queue_full),
    .accepting_i  (accepting),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ubh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  ubh_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .accepting_o (accepting),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
